// ===== rtl/core/pfbrxf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfbrxf_pkg
// Shared types and constants for the page framebuffer with rectangle xor fill.
// ----------------------------------------------------------------------------
`default_nettype none

package pfbrxf_pkg;

   // default screen geometry
   localparam int SCREEN_WIDTH_DEF = 128;
   localparam int SCREEN_PAGES_DEF = 8;

   // rows held in one byte of the store
   localparam int ROWS_PER_PAGE = 8;
   localparam int ROW_BIT_W     = $clog2(ROWS_PER_PAGE);

   // payload field widths
   localparam int COL_W   = 7;
   localparam int ROW_W   = 6;
   localparam int ADDR_W  = 10;
   localparam int BYTE_W  = 8;
   localparam int PAGE_W  = ROW_W - ROW_BIT_W;

   // item operation codes
   typedef enum logic [0:0] {
      OP_DRAW = 1'b0,
      OP_READ = 1'b1
   } op_type;

endpackage : pfbrxf_pkg

`default_nettype wire

// ===== rtl/core/pfbrxf_req_if.sv =====
// ----------------------------------------------------------------------------
// pfbrxf_req_if
// Request channel: draw a toggled rectangle or read one framebuffer byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfbrxf_req_if
   import pfbrxf_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [0:0]        opcode;
   logic [COL_W-1:0]  corner_a_x;
   logic [ROW_W-1:0]  corner_a_y;
   logic [COL_W-1:0]  corner_b_x;
   logic [ROW_W-1:0]  corner_b_y;
   logic [ADDR_W-1:0] read_address;

   modport source (
      output valid, opcode, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
             read_address,
      input  ready
   );

   modport sink (
      input  valid, opcode, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
             read_address,
      output ready
   );

endinterface : pfbrxf_req_if

`default_nettype wire

// ===== rtl/core/pfbrxf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfbrxf_rsp_if
// Response channel: read reply byte or draw completion.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfbrxf_rsp_if
   import pfbrxf_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              is_read_reply;

   modport source (
      output valid, read_byte, is_read_reply,
      input  ready
   );

   modport sink (
      input  valid, read_byte, is_read_reply,
      output ready
   );

endinterface : pfbrxf_rsp_if

`default_nettype wire

// ===== rtl/core/page_framebuffer_rect_xor_fill.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_rect_xor_fill
// One-bit-per-pixel page framebuffer with rectangle toggle fill and byte reads.
// ----------------------------------------------------------------------------
// The framebuffer is a single SCREEN_WIDTH x SCREEN_PAGES byte memory with a
// registered read; byte index is column + page * SCREEN_WIDTH and bit n of a
// byte is row page*8+n. After reset the block runs a clearing pass over every
// byte, one byte per cycle, during which req_ch.ready stays low. One item is
// handled at a time and each gives one response. A read registers the byte
// from the memory and then loads it into the response register in ST_FINISH.
// A draw sorts its corners, clips to the screen and does one byte
// read-modify-write per cycle over the covered columns and pages, then goes to
// ST_FINISH; a fully clipped draw goes straight to ST_FINISH. The memory port,
// one byte per cycle, sets the draw rate. A new request is taken once the
// previous response has been loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_rect_xor_fill
   import pfbrxf_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int SCREEN_PAGES = SCREEN_PAGES_DEF
) (
   input  wire              clock,
   input  wire              reset,
   pfbrxf_req_if.sink       req_ch,
   pfbrxf_rsp_if.source     rsp_ch
);

   localparam int StoreBytes = SCREEN_WIDTH * SCREEN_PAGES;
   localparam int StoreAw    = $clog2(StoreBytes);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_FINISH
   } state_type;

   // framebuffer memory
   logic [BYTE_W-1:0]  mem_store [StoreBytes];
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               mem_rd_en;
   logic [StoreAw-1:0] mem_rd_addr;
   logic               mem_wr_en;
   logic [StoreAw-1:0] mem_wr_addr;
   logic [BYTE_W-1:0]  mem_wr_data;

   // control and sweep registers
   state_type          state_ff, state_in;
   logic [StoreAw-1:0] clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]   x_ff, x_in;
   logic [COL_W-1:0]   x_end_ff, x_end_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [PAGE_W-1:0]  page_lo_ff, page_lo_in;
   logic [PAGE_W-1:0]  page_hi_ff, page_hi_in;
   logic [PAGE_W-1:0]  page_end_ff, page_end_in;
   logic [ROW_BIT_W-1:0] first_bit_ff, first_bit_in;
   logic [ROW_BIT_W-1:0] last_bit_ff, last_bit_in;
   logic               is_read_ff, is_read_in;
   logic               rd_oob_ff, rd_oob_in;
   logic               wr_pending_ff, wr_pending_in;
   logic [StoreAw-1:0] wr_addr_ff, wr_addr_in;
   logic [BYTE_W-1:0]  wr_mask_ff, wr_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_is_read_ff, rsp_is_read_in;

   // combinational helpers
   logic               req_xfer;
   logic [COL_W-1:0]   x_lo, x_hi;
   logic [ROW_W-1:0]   y_lo, y_hi;
   logic [PAGE_W-1:0]  pg_lo, pg_hi;
   logic               draw_empty;
   logic [31:0]        rd_addr_ext;
   logic [31:0]        draw_addr_ext;
   logic [ROW_BIT_W-1:0] mask_first, mask_last;
   logic [BYTE_W-1:0]  draw_mask;
   logic               sweep_last;

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign req_xfer             = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.read_byte     = rsp_byte_ff;
   assign rsp_ch.is_read_reply = rsp_is_read_ff;

   // corner sort and clip bounds
   always_comb begin
      x_lo  = (req_ch.corner_a_x < req_ch.corner_b_x) ? req_ch.corner_a_x : req_ch.corner_b_x;
      x_hi  = (req_ch.corner_a_x < req_ch.corner_b_x) ? req_ch.corner_b_x : req_ch.corner_a_x;
      y_lo  = (req_ch.corner_a_y < req_ch.corner_b_y) ? req_ch.corner_a_y : req_ch.corner_b_y;
      y_hi  = (req_ch.corner_a_y < req_ch.corner_b_y) ? req_ch.corner_b_y : req_ch.corner_a_y;
      pg_lo = y_lo[ROW_W-1:ROW_BIT_W];
      pg_hi = y_hi[ROW_W-1:ROW_BIT_W];
      draw_empty = (32'(x_lo) >= 32'(SCREEN_WIDTH)) || (32'(pg_lo) >= 32'(SCREEN_PAGES));
      rd_addr_ext = 32'(req_ch.read_address);
   end

   // byte address and mask of the current sweep position
   always_comb begin
      draw_addr_ext = 32'(x_ff) + 32'(page_ff) * 32'(SCREEN_WIDTH);
      mask_first    = (page_ff == page_lo_ff) ? first_bit_ff : ROW_BIT_W'(0);
      mask_last     = (page_ff == page_hi_ff) ? last_bit_ff : ROW_BIT_W'(ROWS_PER_PAGE - 1);
      draw_mask     = (BYTE_W'({BYTE_W{1'b1}}) << mask_first)
                    & (BYTE_W'({BYTE_W{1'b1}}) >> (ROW_BIT_W'(ROWS_PER_PAGE - 1) - mask_last));
      sweep_last    = (x_ff == x_end_ff) && (page_ff == page_end_ff);
   end

   // memory port control
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = draw_addr_ext[StoreAw-1:0];
      if (state_ff == ST_DRAW) begin
         mem_rd_en = 1'b1;
      end else if (req_xfer && (req_ch.opcode == OP_READ)) begin
         mem_rd_en   = (rd_addr_ext < 32'(StoreBytes));
         mem_rd_addr = rd_addr_ext[StoreAw-1:0];
      end
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = wr_pending_ff;
         mem_wr_addr = wr_addr_ff;
         mem_wr_data = rd_data_ff ^ wr_mask_ff;
      end
   end

   // framebuffer storage
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem_store[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem_store[mem_rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      x_in           = x_ff;
      x_end_in       = x_end_ff;
      page_in        = page_ff;
      page_lo_in     = page_lo_ff;
      page_hi_in     = page_hi_ff;
      page_end_in    = page_end_ff;
      first_bit_in   = first_bit_ff;
      last_bit_in    = last_bit_ff;
      is_read_in     = is_read_ff;
      rd_oob_in      = rd_oob_ff;
      wr_pending_in  = 1'b0;
      wr_addr_in     = draw_addr_ext[StoreAw-1:0];
      wr_mask_in     = draw_mask;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_is_read_in = rsp_is_read_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + StoreAw'(1);
            if (32'(clr_addr_ff) == 32'(StoreBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               is_read_in   = (req_ch.opcode == OP_READ);
               rd_oob_in    = !(rd_addr_ext < 32'(StoreBytes));
               x_in         = x_lo;
               x_end_in     = (32'(x_hi) < 32'(SCREEN_WIDTH)) ? x_hi
                                                              : COL_W'(SCREEN_WIDTH - 1);
               page_in      = pg_lo;
               page_lo_in   = pg_lo;
               page_hi_in   = pg_hi;
               page_end_in  = (32'(pg_hi) < 32'(SCREEN_PAGES)) ? pg_hi
                                                               : PAGE_W'(SCREEN_PAGES - 1);
               first_bit_in = y_lo[ROW_BIT_W-1:0];
               last_bit_in  = y_hi[ROW_BIT_W-1:0];
               if ((req_ch.opcode == OP_READ) || draw_empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            // read issued this cycle, write back next cycle
            wr_pending_in = 1'b1;
            if (sweep_last) begin
               state_in = ST_FINISH;
            end else if (page_ff == page_end_ff) begin
               page_in = page_lo_ff;
               x_in    = x_ff + COL_W'(1);
            end else begin
               page_in = page_ff + PAGE_W'(1);
            end
         end
         ST_FINISH: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_is_read_in = is_read_ff;
               rsp_byte_in    = (is_read_ff && !rd_oob_ff) ? rd_data_ff : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         wr_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         wr_pending_ff <= wr_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff           <= x_in;
      x_end_ff       <= x_end_in;
      page_ff        <= page_in;
      page_lo_ff     <= page_lo_in;
      page_hi_ff     <= page_hi_in;
      page_end_ff    <= page_end_in;
      first_bit_ff   <= first_bit_in;
      last_bit_ff    <= last_bit_in;
      is_read_ff     <= is_read_in;
      rd_oob_ff      <= rd_oob_in;
      wr_addr_ff     <= wr_addr_in;
      wr_mask_ff     <= wr_mask_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

endmodule : page_framebuffer_rect_xor_fill

`default_nettype wire
